/* rtl/cclm_pkg.sv */
// Package with the shared types, character constants and text tables of the chat command matcher.
`timescale 1ns / 1ps

package cclm_pkg;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_USER   = 3'd1,
        PH_SKIP   = 3'd2,
        PH_HASH   = 3'd3,
        PH_CMD    = 3'd4,
        PH_UNK    = 3'd5,
        PH_RST    = 3'd6,
        PH_BKP    = 3'd7
    } phase_t;

    typedef logic [1:0] code_t;

    localparam code_t CODE_UNKNOWN = 2'd0;
    localparam code_t CODE_RESTART = 2'd1;
    localparam code_t CODE_BACKUP  = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [7:0] CHAR_HASH     = 8'h23;
    localparam logic [7:0] CHAR_COLON    = 8'h3A;
    localparam logic [7:0] CHAR_LBRACKET = 8'h5B;

    localparam logic [2:0] MARKER_LEN  = 3'd6;
    localparam logic [3:0] RESTART_LEN = 4'd7;
    localparam logic [3:0] BACKUP_LEN  = 4'd6;
    localparam logic [3:0] CMD_POS_MAX = 4'd15;

    // Matcher state apart from the line length, whose width follows the line limit.
    typedef struct packed {
        phase_t     phase;
        logic [2:0] marker_matched;
        logic [3:0] command_position;
        logic       restart_ok;
        logic       backup_ok;
    } cclm_state_t;

    localparam cclm_state_t STATE_RESET = '{
        phase:            PH_SEARCH,
        marker_matched:   3'd0,
        command_position: 4'd0,
        restart_ok:       1'b1,
        backup_ok:        1'b1
    };

    function automatic logic [7:0] marker_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h5B; // [
            3'd1:    c = 8'h43; // C
            3'd2:    c = 8'h48; // H
            3'd3:    c = 8'h41; // A
            3'd4:    c = 8'h54; // T
            3'd5:    c = 8'h5D; // ]
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] restart_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h72; // r
            4'd1:    c = 8'h65; // e
            4'd2:    c = 8'h73; // s
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h61; // a
            4'd5:    c = 8'h72; // r
            4'd6:    c = 8'h74; // t
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] backup_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h62; // b
            4'd1:    c = 8'h61; // a
            4'd2:    c = 8'h63; // c
            4'd3:    c = 8'h6B; // k
            4'd4:    c = 8'h75; // u
            4'd5:    c = 8'h70; // p
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* rtl/cclm_step.sv */
// Next-state logic that advances the matcher state by one buffer byte.
`timescale 1ns / 1ps

module cclm_step
    import cclm_pkg::*;
#(
    parameter int MAX_LINE = 512,
    localparam int LEN_W = $clog2(MAX_LINE + 2)
)
(
    input  cclm_state_t      state,
    input  logic [LEN_W-1:0] line_len,
    input  logic [7:0]       data_byte,
    output cclm_state_t      state_next,
    output logic [LEN_W-1:0] line_len_next,
    output code_t            code
);

    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LINE);

    logic [LEN_W-1:0] len_inc;

    always_comb
    begin
        state_next    = state;
        line_len_next = line_len;
        len_inc       = line_len;

        if (state.phase == PH_SEARCH)
        begin
            if (state.marker_matched < MARKER_LEN &&
                data_byte == marker_char(state.marker_matched))
            begin
                if (state.marker_matched == MARKER_LEN - 3'd1)
                begin
                    state_next.phase          = PH_USER;
                    state_next.marker_matched = 3'd0;
                    line_len_next             = '0;
                end
                else
                begin
                    state_next.marker_matched = state.marker_matched + 3'd1;
                end
            end
            else
            begin
                state_next.marker_matched = (data_byte == CHAR_LBRACKET) ? 3'd1 : 3'd0;
            end
        end
        else if (state.phase inside {PH_USER, PH_SKIP, PH_HASH, PH_CMD})
        begin
            if (data_byte == CHAR_NEWLINE)
            begin
                // End of the chat line: decide the command once and for all.
                if (state.phase == PH_CMD && line_len != '0 && line_len <= LEN_LIMIT &&
                    state.command_position != 4'd0)
                begin
                    if (state.restart_ok && state.command_position == RESTART_LEN)
                        state_next.phase = PH_RST;
                    else if (state.backup_ok && state.command_position == BACKUP_LEN)
                        state_next.phase = PH_BKP;
                    else
                        state_next.phase = PH_UNK;
                end
                else
                begin
                    state_next.phase = PH_UNK;
                end
            end
            else
            begin
                if (line_len <= LEN_LIMIT)
                    len_inc = line_len + LEN_W'(1);
                line_len_next = len_inc;

                if (len_inc > LEN_LIMIT)
                begin
                    state_next.phase = PH_UNK;
                end
                else
                begin
                    case (state.phase)
                        PH_USER:
                        begin
                            if (data_byte == CHAR_COLON)
                                state_next.phase = PH_SKIP;
                        end
                        PH_SKIP:
                        begin
                            state_next.phase = PH_HASH;
                        end
                        PH_HASH:
                        begin
                            if (data_byte == CHAR_HASH)
                            begin
                                state_next.phase            = PH_CMD;
                                state_next.command_position = 4'd0;
                                state_next.restart_ok       = 1'b1;
                                state_next.backup_ok        = 1'b1;
                            end
                            else
                            begin
                                state_next.phase = PH_UNK;
                            end
                        end
                        default:
                        begin
                            if (state.command_position >= RESTART_LEN ||
                                restart_char(state.command_position) != data_byte)
                                state_next.restart_ok = 1'b0;
                            if (state.command_position >= BACKUP_LEN ||
                                backup_char(state.command_position) != data_byte)
                                state_next.backup_ok = 1'b0;
                            if (state.command_position < CMD_POS_MAX)
                                state_next.command_position = state.command_position + 4'd1;
                        end
                    endcase
                end
            end
        end

        case (state_next.phase)
            PH_RST:  code = CODE_RESTART;
            PH_BKP:  code = CODE_BACKUP;
            default: code = CODE_UNKNOWN;
        endcase
    end

endmodule

/* rtl/chat_command_line_matcher.sv */
// Top level of the chat command matcher: input register, match state and result register.
`timescale 1ns / 1ps
// A result reaches command_valid once the accepted final byte of a buffer moves from the
// input register into the result register, or later while the previous result still waits.
// Throughput: one byte per cycle, set by the update of the match state from the input
// register; only a final byte stalls, behind a result that is still waiting.
// Reset (rst_n low, asynchronous) empties the input and result registers and returns the
// matcher to the marker search.

module chat_command_line_matcher
    import cclm_pkg::*;
#(
    parameter int MAX_LINE = 512
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       data_valid,
    output logic       data_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,

    output logic       command_valid,
    input  logic       command_stall,
    output logic [1:0] command_code
);

    localparam int LEN_W = $clog2(MAX_LINE + 2);

    // The input register holds one request. It drains into the match state every cycle,
    // except a final byte, which also needs the result register free. Ordinary bytes
    // keep flowing while a finished result waits at the output.
    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             s1_last_reg;

    cclm_state_t      state_reg;
    logic [LEN_W-1:0] line_len_reg;

    logic             res_valid_reg;
    code_t            res_code_reg;

    cclm_state_t      step_state;
    logic [LEN_W-1:0] step_len;
    code_t            step_code;

    logic res_free;
    logic s1_move;
    logic s1_load;

    assign res_free   = !res_valid_reg || !command_stall;
    assign s1_move    = s1_valid_reg && (!s1_last_reg || res_free);
    assign data_stall = s1_valid_reg && !s1_move;
    assign s1_load    = data_valid && !data_stall;

    cclm_step #(
        .MAX_LINE(MAX_LINE)
    ) u_step (
        .state        (state_reg),
        .line_len     (line_len_reg),
        .data_byte    (s1_byte_reg),
        .state_next   (step_state),
        .line_len_next(step_len),
        .code         (step_code)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            state_reg     <= STATE_RESET;
            line_len_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
            begin
                // The final byte of a buffer leaves the matcher ready for the next buffer.
                if (s1_last_reg)
                begin
                    state_reg    <= STATE_RESET;
                    line_len_reg <= '0;
                end
                else
                begin
                    state_reg    <= step_state;
                    line_len_reg <= step_len;
                end
            end

            if (s1_move && s1_last_reg)
                res_valid_reg <= 1'b1;
            else if (!command_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (s1_move && s1_last_reg)
            res_code_reg <= step_code;
    end

    assign command_valid = res_valid_reg;
    assign command_code  = res_code_reg;

    // The input register only holds back a final byte while a result is still waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        data_stall |-> (s1_last_reg && res_valid_reg && command_stall))
        else $error("input stalled without a waiting result");

    // A buffer's final byte returns the matcher to the marker search.
    a_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_last_reg) |=> (state_reg.phase == PH_SEARCH && line_len_reg == '0))
        else $error("matcher not reset after final byte");

    // No line is counted while searching for the marker.
    a_search_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_SEARCH) |-> (line_len_reg == '0 &&
                                            state_reg.marker_matched < MARKER_LEN))
        else $error("line length or marker count out of range during search");

    // Only the three defined command codes are ever offered.
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        command_valid |-> (command_code == CODE_UNKNOWN || command_code == CODE_RESTART ||
                           command_code == CODE_BACKUP))
        else $error("undefined command code");

endmodule

/* tb/tb_chat_command_line_matcher.sv */
// Self-checking testbench that streams text buffers into the chat command matcher.
`timescale 1ns / 1ps

module tb_chat_command_line_matcher;
    import cclm_pkg::*;

    // The line limit of the block. The long-line rows of the directed table are sized from it.
    localparam int MAX_LINE = 512;

    // Width of a text cell in the directed table, in bytes. Text is right-aligned, and
    // the zero bytes in front of a short literal are skipped.
    localparam int TXT_BYTES = 48;

    localparam int NUM_ROWS       = 25;
    localparam int RANDOM_BYTES   = 250;
    localparam int RANDOM_BUFFERS = 14;
    localparam int IDLE_PERCENT   = 17;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;

    localparam logic [47:0] MARKER_TXT  = "[CHAT]";
    localparam logic [55:0] RESTART_TXT = "restart";
    localparam logic [47:0] BACKUP_TXT  = "backup";

    // One request on the byte channel. When typed is set, the command code of the buffer
    // is the one given here and not the one the line predictor works out.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        code_t      code;
    } request_t;

    // One row of the directed table: head text, then pad_n copies of pad_ch, then tail
    // text. The final byte of the row carries last_byte.
    typedef struct packed {
        logic [TXT_BYTES*8-1:0] head;
        logic [15:0]            pad_n;
        logic [7:0]             pad_ch;
        logic [TXT_BYTES*8-1:0] tail;
        logic                   typed;
        code_t                  code;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       data_valid = 1'b0;
    logic       data_stall;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       command_valid;
    logic       command_stall = 1'b0;
    logic [1:0] command_code;

    // Side information that travels with the request that is currently driven.
    logic       req_typed = 1'b0;
    code_t      req_code = CODE_UNKNOWN;

    // Random idling on both channels is switched off while this is set.
    logic       steady_phase = 1'b0;

    logic [7:0] buf_q[$];
    code_t      code_q[$];
    int         mismatches = 0;
    int         stuck_cycles = 0;

    // Line predictor state.
    phase_t      ph;
    logic [2:0]  mk_cnt;
    int          line_len;
    logic [3:0]  cmd_pos;
    logic        rs_ok;
    logic        bk_ok;

    chat_command_line_matcher #(
        .MAX_LINE (MAX_LINE)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_valid    (data_valid),
        .data_stall    (data_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .command_valid (command_valid),
        .command_stall (command_stall),
        .command_code  (command_code)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Line predictor
    // ------------------------------------------------------------------

    task automatic matcher_reset();
        ph       = PH_SEARCH;
        mk_cnt   = 3'd0;
        line_len = 0;
        cmd_pos  = 4'd0;
        rs_ok    = 1'b1;
        bk_ok    = 1'b1;
    endtask

    // Advances the predictor by one byte. On the final byte of a buffer the byte is
    // handled first, since it may be the newline, then the code is read off the phase
    // and the state starts over for the next buffer.
    task automatic predict_byte(input logic [7:0] b, input logic last,
                                output logic produced, output code_t code);
        produced = 1'b0;
        code     = CODE_UNKNOWN;
        if (ph == PH_SEARCH) begin
            if (mk_cnt < MARKER_LEN &&
                b == MARKER_TXT[8*(int'(MARKER_LEN) - 1 - int'(mk_cnt)) +: 8]) begin
                mk_cnt = mk_cnt + 3'd1;
                if (mk_cnt == MARKER_LEN) begin
                    ph       = PH_USER;
                    mk_cnt   = 3'd0;
                    line_len = 0;
                end
            end
            else begin
                // A broken marker may itself be the start of a new one.
                mk_cnt = (b == CHAR_LBRACKET) ? 3'd1 : 3'd0;
            end
        end
        else if (ph <= PH_CMD) begin
            if (b == CHAR_NEWLINE) begin
                // The newline settles the line: only a complete, exact command counts.
                if (ph == PH_CMD && line_len != 0 && line_len <= MAX_LINE && cmd_pos != 0) begin
                    if (rs_ok && cmd_pos == RESTART_LEN)
                        ph = PH_RST;
                    else if (bk_ok && cmd_pos == BACKUP_LEN)
                        ph = PH_BKP;
                    else
                        ph = PH_UNK;
                end
                else begin
                    ph = PH_UNK;
                end
            end
            else begin
                // The length counter stops one past the limit, and an overlong line is
                // decided at once.
                if (line_len <= MAX_LINE)
                    line_len++;
                if (line_len > MAX_LINE) begin
                    ph = PH_UNK;
                end
                else begin
                    case (ph)
                        PH_USER:
                            if (b == CHAR_COLON)
                                ph = PH_SKIP;
                        PH_SKIP:
                            ph = PH_HASH;
                        PH_HASH:
                            if (b == CHAR_HASH) begin
                                ph      = PH_CMD;
                                cmd_pos = 4'd0;
                                rs_ok   = 1'b1;
                                bk_ok   = 1'b1;
                            end
                            else begin
                                ph = PH_UNK;
                            end
                        default:
                        begin
                            if (cmd_pos >= RESTART_LEN ||
                                b != RESTART_TXT[8*(int'(RESTART_LEN) - 1 - int'(cmd_pos)) +: 8])
                                rs_ok = 1'b0;
                            if (cmd_pos >= BACKUP_LEN ||
                                b != BACKUP_TXT[8*(int'(BACKUP_LEN) - 1 - int'(cmd_pos)) +: 8])
                                bk_ok = 1'b0;
                            if (cmd_pos < CMD_POS_MAX)
                                cmd_pos = cmd_pos + 4'd1;
                        end
                    endcase
                end
            end
        end
        if (last) begin
            produced = 1'b1;
            if (ph == PH_RST)
                code = CODE_RESTART;
            else if (ph == PH_BKP)
                code = CODE_BACKUP;
            else
                code = CODE_UNKNOWN;
            matcher_reset();
        end
    endtask

    initial matcher_reset();

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------

    function automatic dir_row_t row_of(input logic [TXT_BYTES*8-1:0] head,
                                        input int pad_n, input logic [7:0] pad_ch,
                                        input logic [TXT_BYTES*8-1:0] tail,
                                        input logic typed, input code_t code);
        dir_row_t r;
        r.head   = head;
        r.pad_n  = pad_n[15:0];
        r.pad_ch = pad_ch;
        r.tail   = tail;
        r.typed  = typed;
        r.code   = code;
        return r;
    endfunction

    // Rows with an obvious answer carry it; the rest are left to the predictor.
    function automatic dir_row_t dir_row(input int idx);
        dir_row_t r;
        case (idx)
            // Both commands, well formed.
            0:  r = row_of("[CHAT]user: #restart\n", 0, "u", "", 1'b1, CODE_RESTART);
            1:  r = row_of("[CHAT]user: #backup\n", 0, "u", "", 1'b1, CODE_BACKUP);
            // No marker, and a marker that completes on the final byte.
            2:  r = row_of("no marker here", 0, "u", "", 1'b1, CODE_UNKNOWN);
            3:  r = row_of("[CHAT]", 0, "u", "", 1'b1, CODE_UNKNOWN);
            // The buffer ends before the newline.
            4:  r = row_of("[CHAT]a: #restart", 0, "u", "", 1'b1, CODE_UNKNOWN);
            // Empty line, no colon, nothing after the colon, no hash.
            5:  r = row_of("[CHAT]\n", 0, "u", "", 1'b1, CODE_UNKNOWN);
            6:  r = row_of("[CHAT]nocolon #restart\n", 0, "u", "", 1'b1, CODE_UNKNOWN);
            7:  r = row_of("[CHAT]u:\n", 0, "u", "", 1'b1, CODE_UNKNOWN);
            8:  r = row_of("[CHAT]u: x#restart\n", 0, "u", "", 1'b1, CODE_UNKNOWN);
            // Nothing after the hash, and commands that are near misses.
            9:  r = row_of("[CHAT]u: #\n", 0, "u", "", 1'b1, CODE_UNKNOWN);
            10: r = row_of("[CHAT]u: #restar\n", 0, "u", "", 1'b1, CODE_UNKNOWN);
            11: r = row_of("[CHAT]u: #restarts\n", 0, "u", "", 1'b1, CODE_UNKNOWN);
            12: r = row_of("[CHAT]u: #backu\n", 0, "u", "", 1'b1, CODE_UNKNOWN);
            13: r = row_of("[CHAT]u: #Backup\n", 0, "u", "", 1'b1, CODE_UNKNOWN);
            // A command long enough to saturate the position counter.
            14: r = row_of("[CHAT]u: #restartrestartrestart\n", 0, "u", "", 1'b1,
                           CODE_UNKNOWN);
            // Bytes after the newline and a second marker are ignored.
            15: r = row_of("[CHAT]u: #backup\nmore text", 0, "u", "", 1'b1, CODE_BACKUP);
            16: r = row_of("[CHAT]u: #backup\n[CHAT]u: #restart\n", 0, "u", "", 1'b1,
                           CODE_BACKUP);
            // A broken marker before the real one, a high byte as the username and an
            // arbitrary byte in the skipped slot.
            17: r = row_of("[C[[CHAT]\377:x#restart\n", 0, "u", "", 1'b1, CODE_RESTART);
            // Only the first colon ends the username.
            18: r = row_of("[CHAT]a:b:#backup\n", 0, "u", "", 1'b1, CODE_UNKNOWN);
            // Single-byte buffers at both byte extremes.
            19: r = row_of("", 1, 8'h00, "", 1'b1, CODE_UNKNOWN);
            20: r = row_of("", 1, 8'hFF, "", 1'b1, CODE_UNKNOWN);
            // A line of exactly the limit, and one byte over.
            21: r = row_of("[CHAT]", MAX_LINE - 10, "u", ": #restart\n", 1'b1, CODE_RESTART);
            22: r = row_of("[CHAT]", MAX_LINE - 9, "u", ": #restart\n", 1'b1, CODE_UNKNOWN);
            // The hash itself falls into the skipped slot.
            23: r = row_of("[CHAT]u:#restart\n", 0, "u", "", 1'b1, CODE_UNKNOWN);
            // A second marker inside the username.
            default: r = row_of("[CHAT][CHAT]u: #backup\n", 0, "u", "", 1'b0, CODE_UNKNOWN);
        endcase
        return r;
    endfunction

    task automatic push_text(input logic [TXT_BYTES*8-1:0] t);
        for (int i = TXT_BYTES - 1; i >= 0; i--)
            if (t[8*i +: 8] != 8'h00)
                buf_q.push_back(t[8*i +: 8]);
    endtask

    // ------------------------------------------------------------------
    // Random buffers
    // ------------------------------------------------------------------

    // Mostly chat lines with random content: a few stray bytes, the marker, a username,
    // the colon and skipped byte, a hash and a command that is exact, cut short, too
    // long, altered or random. Some lose their newline or get one byte broken. The rest
    // is plain noise.
    task automatic make_random_buffer();
        logic [55:0] word;
        int          wlen;
        int          n;
        int          sel;
        buf_q.delete();
        if ($urandom_range(9) == 0) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                buf_q.push_back(8'($urandom_range(255)));
        end
        else begin
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                buf_q.push_back($urandom_range(1) ? MARKER_TXT[8*$urandom_range(5) +: 8]
                                                  : 8'($urandom_range(255)));
            push_text(MARKER_TXT);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
                buf_q.push_back(8'($urandom_range(255)));
            buf_q.push_back(CHAR_COLON);
            buf_q.push_back(8'($urandom_range(255)));
            buf_q.push_back(CHAR_HASH);
            if ($urandom_range(1)) begin
                word = RESTART_TXT;
                wlen = int'(RESTART_LEN);
            end
            else begin
                word = {8'h00, BACKUP_TXT};
                wlen = int'(BACKUP_LEN);
            end
            sel = $urandom_range(7);
            case (sel)
                0:       n = $urandom_range(0, wlen - 1);
                1:       n = wlen + $urandom_range(1, 9);
                2:       n = $urandom_range(0, 16);
                default: n = wlen;
            endcase
            for (int i = 0; i < n; i++) begin
                if (sel == 2 || i >= wlen)
                    buf_q.push_back(8'($urandom_range(255)));
                else
                    buf_q.push_back(word[8*(wlen - 1 - i) +: 8]);
            end
            if (sel == 3)
                buf_q[buf_q.size() - 1 - $urandom_range(wlen - 1)] = 8'($urandom_range(255));
            if ($urandom_range(9) != 0)
                buf_q.push_back(CHAR_NEWLINE);
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                buf_q.push_back(8'($urandom_range(255)));
            if ($urandom_range(6) == 0)
                buf_q[$urandom_range(buf_q.size() - 1)] = 8'($urandom_range(255));
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    // Drives one request at the falling edge, after a random idle gap, and holds it
    // until the block takes it at a rising edge.
    task automatic send_request(input request_t r);
        @(negedge clk);
        while (!steady_phase && $urandom_range(99) < IDLE_PERCENT) begin
            data_valid <= 1'b0;
            @(negedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= r.data;
        last_byte  <= r.last;
        req_typed  <= r.typed;
        req_code   <= r.code;
        do
            @(posedge clk);
        while (data_stall);
    endtask

    task automatic send_buffer(input logic typed, input code_t code);
        request_t r;
        for (int i = 0; i < buf_q.size(); i++) begin
            r.data  = buf_q[i];
            r.last  = (i == buf_q.size() - 1);
            r.typed = typed;
            r.code  = code;
            send_request(r);
        end
    endtask

    // Takes the byte channel down and waits for every outstanding command code.
    task automatic drain_results();
        @(negedge clk);
        data_valid <= 1'b0;
        while (code_q.size() != 0)
            @(posedge clk);
    endtask

    // The result side stalls at random, except in the steady stretch.
    always @(negedge clk)
        command_stall <= !steady_phase && ($urandom_range(99) < IDLE_PERCENT);

    // ------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------

    // Every accepted request advances the predictor; a final byte queues the code
    // that the buffer must produce.
    always @(posedge clk) begin : take_request
        logic  produced;
        code_t code;
        if (rst_n && data_valid && !data_stall) begin
            predict_byte(data_byte, last_byte, produced, code);
            if (produced)
                code_q.push_back(req_typed ? req_code : code);
        end
    end

    always @(posedge clk) begin : check_result
        code_t expected_code;
        if (rst_n && command_valid && !command_stall) begin
            if (code_q.size() == 0) begin
                $display("%0t: command_code expected none, actual %0d", $time, command_code);
                mismatches++;
            end
            else begin
                expected_code = code_q.pop_front();
                if (command_code !== expected_code) begin
                    $display("%0t: command_code expected %0d, actual %0d",
                             $time, expected_code, command_code);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge clk) begin
        if ((data_valid && !data_stall) || (command_valid && !command_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin : run
        dir_row_t r;
        int       sent;
        int       buffers;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int row = 0; row < NUM_ROWS; row++) begin
            r = dir_row(row);
            buf_q.delete();
            push_text(r.head);
            for (int i = 0; i < r.pad_n; i++)
                buf_q.push_back(r.pad_ch);
            push_text(r.tail);
            send_buffer(r.typed, r.code);
        end
        drain_results();

        // Random buffers; a stretch in the middle runs without idling, and once the
        // sender holds off until every code has come back.
        sent    = 0;
        buffers = 0;
        while (sent < RANDOM_BYTES || buffers < RANDOM_BUFFERS) begin
            steady_phase = (buffers >= 3 && buffers < 10);
            if (buffers == 11)
                drain_results();
            make_random_buffer();
            sent += buf_q.size();
            send_buffer(1'b0, CODE_UNKNOWN);
            buffers++;
        end
        steady_phase = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && code_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* chat_command_line_matcher.f */
rtl/cclm_pkg.sv
rtl/cclm_step.sv
rtl/chat_command_line_matcher.sv
tb/tb_chat_command_line_matcher.sv
